/* rtl/core/detector_deadtime_filter_unit_assert.svh */
// assertion macros for the dead-time filter
`ifndef DETECTOR_DEADTIME_FILTER_UNIT_ASSERT_SVH
`define DETECTOR_DEADTIME_FILTER_UNIT_ASSERT_SVH

// condition holds on every enabled clock edge
`define DDTF_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DDTF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define DDTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ddtf_pkg.sv */
// shared types and constants of the dead-time filter
package ddtf_pkg;

    localparam int NUM_DETECTORS = 4096;
    localparam int NUM_GROUPS    = 4096;
    localparam int TIME_BITS     = 48;

    // fixed field widths
    localparam int ID_W   = 12;
    localparam int GRP_W  = 12;
    localparam int EVT_W  = 48;
    localparam int DT_W   = 32;
    localparam int CNT_W  = 32;

    localparam int MAP_AW    = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
    localparam int WIN_AW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int SUM_W     = ((TIME_BITS > DT_W) ? TIME_BITS : DT_W) + 1;
    localparam int CLR_DEPTH = (NUM_DETECTORS > NUM_GROUPS) ? NUM_DETECTORS : NUM_GROUPS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // register word select
    localparam logic REG_DEAD_TIME   = 1'b0;
    localparam logic REG_PARALYZABLE = 1'b1;

    // command codes
    localparam logic CMD_EVENT     = 1'b0;
    localparam logic CMD_MAP_WRITE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [EVT_W-1:0] event_time;
        logic [ID_W-1:0]  detector_id;
        logic             already_dropped;
        logic [GRP_W-1:0] group_value;
    } t_in_item;

    typedef struct packed {
        logic             was_event;
        logic             drop_flag;
        logic [GRP_W-1:0] group_id;
        logic [CNT_W-1:0] kept_total;
        logic [CNT_W-1:0] dropped_total;
    } t_out_item;

    // pipeline control from the top level
    typedef struct packed {
        logic             adv;
        logic             clr_active;
        logic [CLR_W-1:0] clr_cnt;
    } t_ctl;

    // item after the map lookup stage
    typedef struct packed {
        logic                 valid;
        logic                 is_event;
        logic                 pre;
        logic                 id_ok;
        logic [TIME_BITS-1:0] t;
        logic [SUM_W-1:0]     sum;
        logic [GRP_W-1:0]     ack_grp;
    } t_s1;

endpackage

/* rtl/core/ddtf_ram.sv */
// generic single-write, single-read ram with registered read
module ddtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/ddtf_map_lookup.sv */
// detector-to-group map memory and the lookup stage
module ddtf_map_lookup (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ddtf_pkg::t_ctl              i_ctl,
    input  logic                        i_in_fire,
    input  ddtf_pkg::t_in_item          i_in_item,
    input  logic [ddtf_pkg::DT_W-1:0]   i_dead_time,
    output ddtf_pkg::t_s1               o_s1,
    output logic [ddtf_pkg::GRP_W-1:0]  o_s1_grp
);
    import ddtf_pkg::*;

    t_s1                  r_s1;
    t_s1                  n_s1;
    logic                 id_ok;
    logic [GRP_W-1:0]     gv_sat;
    logic [TIME_BITS-1:0] t_in;
    logic                 map_we;
    logic [MAP_AW-1:0]    map_waddr;
    logic [GRP_W-1:0]     map_wdata;
    logic [GRP_W-1:0]     map_rdata;
    logic [GRP_W-1:0]     grp_raw;

    always_comb begin
        id_ok  = 32'(i_in_item.detector_id) < 32'(NUM_DETECTORS);
        gv_sat = (32'(i_in_item.group_value) > 32'(NUM_GROUPS - 1))
               ? GRP_W'(NUM_GROUPS - 1) : i_in_item.group_value;
        t_in   = TIME_BITS'(i_in_item.event_time);

        n_s1.valid    = i_in_fire;
        n_s1.is_event = (i_in_item.cmd == CMD_EVENT);
        n_s1.pre      = i_in_item.already_dropped;
        n_s1.id_ok    = id_ok;
        n_s1.t        = t_in;
        n_s1.sum      = SUM_W'(t_in) + SUM_W'(i_dead_time);
        n_s1.ack_grp  = id_ok ? gv_sat : '0;

        // clearing pass has priority; no item enters while it runs
        if (i_ctl.clr_active) begin
            map_we    = 32'(i_ctl.clr_cnt) < 32'(NUM_DETECTORS);
            map_waddr = MAP_AW'(i_ctl.clr_cnt);
            map_wdata = '0;
        end else begin
            map_we    = i_in_fire && (i_in_item.cmd == CMD_MAP_WRITE) && id_ok;
            map_waddr = MAP_AW'(i_in_item.detector_id);
            map_wdata = gv_sat;
        end
    end

    ddtf_ram #(
        .WIDTH (GRP_W),
        .DEPTH (NUM_DETECTORS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (i_ctl.adv),
        .i_raddr (MAP_AW'(i_in_item.detector_id)),
        .o_rdata (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s1 <= n_s1;
        end
    end

    // out-of-range id or group falls back to group zero
    always_comb begin
        grp_raw  = r_s1.id_ok ? map_rdata : '0;
        o_s1_grp = (32'(grp_raw) >= 32'(NUM_GROUPS)) ? '0 : grp_raw;
    end

    assign o_s1 = r_s1;
endmodule

/* rtl/core/ddtf_window_update.sv */
// window-end memory, read-modify-write with forwarding, counters, result register
module ddtf_window_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ddtf_pkg::t_ctl              i_ctl,
    input  ddtf_pkg::t_s1               i_s1,
    input  logic [ddtf_pkg::GRP_W-1:0]  i_s1_grp,
    input  logic                        i_paralyzable,
    output logic                        o_out_valid,
    output ddtf_pkg::t_out_item         o_out_item
);
    import ddtf_pkg::*;

    t_s1              r_s2;
    logic [GRP_W-1:0] r_s2_grp;
    logic             r_fw_valid;
    logic [GRP_W-1:0] r_fw_grp;
    logic [SUM_W-1:0] r_fw_data;
    logic [CNT_W-1:0] r_kept;
    logic [CNT_W-1:0] n_kept;
    logic [CNT_W-1:0] r_drop;
    logic [CNT_W-1:0] n_drop;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;
    logic [SUM_W-1:0] win_rdata;
    logic [SUM_W-1:0] cur_end;
    logic             live;
    logic             late;
    logic             upd;
    logic             win_we;
    logic [WIN_AW-1:0] win_waddr;
    logic [SUM_W-1:0] win_wdata;

    always_comb begin
        // last write may have hit the entry read in the same cycle
        cur_end = (r_fw_valid && (r_fw_grp == r_s2_grp)) ? r_fw_data : win_rdata;
        late    = SUM_W'(r_s2.t) < cur_end;
        live    = r_s2.valid && r_s2.is_event && !r_s2.pre;
        upd     = i_ctl.adv && live && (!late || i_paralyzable);

        n_kept = r_kept;
        n_drop = r_drop;
        if (live) begin
            if (late) begin
                n_drop = r_drop + 1'b1;
            end else begin
                n_kept = r_kept + 1'b1;
            end
        end

        n_out_item.was_event     = r_s2.is_event;
        n_out_item.drop_flag     = r_s2.is_event && (r_s2.pre || late);
        n_out_item.group_id      = r_s2.is_event ? r_s2_grp : r_s2.ack_grp;
        n_out_item.kept_total    = n_kept;
        n_out_item.dropped_total = n_drop;

        if (i_ctl.clr_active) begin
            win_we    = 32'(i_ctl.clr_cnt) < 32'(NUM_GROUPS);
            win_waddr = WIN_AW'(i_ctl.clr_cnt);
            win_wdata = '0;
        end else begin
            win_we    = upd;
            win_waddr = WIN_AW'(r_s2_grp);
            win_wdata = r_s2.sum;
        end
    end

    ddtf_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NUM_GROUPS)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (win_wdata),
        .i_re    (i_ctl.adv),
        .i_raddr (WIN_AW'(i_s1_grp)),
        .o_rdata (win_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_kept      <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s2        <= i_s1;
            r_s2_grp    <= i_s1_grp;
            r_kept      <= n_kept;
            r_drop      <= n_drop;
            r_out_valid <= r_s2.valid;
            r_out_item  <= n_out_item;
            if (upd) begin
                r_fw_valid <= 1'b1;
                r_fw_grp   <= r_s2_grp;
                r_fw_data  <= r_s2.sum;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule

/* rtl/core/detector_deadtime_filter_unit.sv */
// top level of the detector dead-time filter
// Takes one detector item per clock while the output is not stalled, once the
// post-reset clearing pass is done. Items travel through three registers: the
// group map read, the window-end read-modify-write, and the result register.
// The accepting edge loads the first of them, and each pipeline advance moves
// the item on to the next. The window-end memory is read as an item enters the
// read-modify-write register and written as it leaves it; a one-entry
// forwarding register covers an item that reads the group written by the item
// right ahead of it. After reset both memories are cleared one entry a cycle,
// over the larger of the detector and group counts (4096 for the default
// sizes), during which no item is accepted; the configuration port works
// throughout. Configuration writes take effect for items accepted later,
// and must be made while no item is in flight.
module detector_deadtime_filter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ddtf_pkg::t_in_item   i_in_item,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ddtf_pkg::t_out_item  o_out_item,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ddtf_pkg::*;

    logic [DT_W-1:0]  r_dead_time;
    logic             r_paralyzable;
    logic             r_clr_active;
    logic [CLR_W-1:0] r_clr_cnt;
    t_ctl             ctl;
    logic             in_fire;
    logic             cfg_wr;
    t_s1              s1;
    logic [GRP_W-1:0] s1_grp;

    // config registers, word select on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_PARALYZABLE) ? 32'(r_paralyzable) : r_dead_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_time   <= '0;
            r_paralyzable <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_DEAD_TIME:   r_dead_time   <= pwdata;
                REG_PARALYZABLE: r_paralyzable <= pwdata[0];
                default:         r_dead_time   <= r_dead_time;
            endcase
        end
    end

    // clearing pass over both memories after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
        end else if (r_clr_active) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // whole pipeline moves when the result register is free or being drained
    always_comb begin
        ctl.adv        = !o_out_valid || i_out_ready;
        ctl.clr_active = r_clr_active;
        ctl.clr_cnt    = r_clr_cnt;
    end

    assign o_in_ready = ctl.adv && !r_clr_active;
    assign in_fire    = i_in_valid && o_in_ready;

    // group map lookup
    ddtf_map_lookup u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_fire   (in_fire),
        .i_in_item   (i_in_item),
        .i_dead_time (r_dead_time),
        .o_s1        (s1),
        .o_s1_grp    (s1_grp)
    );

    // window check, update and result register
    ddtf_window_update u_win (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_s1          (s1),
        .i_s1_grp      (s1_grp),
        .i_paralyzable (r_paralyzable),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item)
    );

`include "detector_deadtime_filter_unit_assert.svh"

    // no result can exist while the memories are being cleared
    `DDTF_ASSERT_IMPLIES(a_no_out_in_clear, i_clk, i_rst_n, r_clr_active, !o_out_valid, "result during clearing pass")
    // a map write acknowledge never reports a drop
    `DDTF_ASSERT_IMPLIES(a_ack_no_drop, i_clk, i_rst_n, o_out_valid && !o_out_item.was_event, !o_out_item.drop_flag, "map ack flagged as dropped")
    // clearing ends only after the last entry
    `DDTF_ASSERT_IMPLIES(a_clr_full, i_clk, i_rst_n, $fell(r_clr_active), $past(r_clr_cnt) == CLR_W'(CLR_DEPTH - 1), "clearing pass cut short")
endmodule
